// ===== hw/rtl/lfps_pkg.sv =====
// Shared types, constants and codes of the line follower PD steering block.
`timescale 1ns / 1ps
package lfps_pkg;

  localparam int DEF_HISTORY_DEPTH = 8;
  localparam int NUM_SENSORS       = 5;
  localparam int TICKS_PER_SEC     = 2000000;
  localparam int TICKS_W           = 21;
  localparam int PERIOD_W          = 20;
  localparam int ERR_W             = 16;
  localparam int WSUM_W            = 11;
  localparam int HITS_W            = 3;
  localparam int ACC_W             = 21;
  localparam int GAIN_W            = 16;
  localparam int DUTY_W            = 8;
  localparam int WEIGHTS_W         = 40;
  localparam int EDIV_BITS         = 15;
  localparam int CDATA_W           = 64;
  localparam int CADDR_W           = 6;

  localparam logic [2:0] REG_WEIGHTS = 3'd0;
  localparam logic [2:0] REG_P_GAIN  = 3'd1;
  localparam logic [2:0] REG_D_FWD   = 3'd2;
  localparam logic [2:0] REG_D_REV   = 3'd3;
  localparam logic [2:0] REG_CRUISE  = 3'd4;
  localparam logic [2:0] REG_PERIOD  = 3'd5;

  localparam logic [GAIN_W-1:0]   RST_P_GAIN = 16'd256;
  localparam logic [DUTY_W-1:0]   RST_CRUISE = 8'd128;
  localparam logic [PERIOD_W-1:0] RST_PERIOD = 20'd10000;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_EDIV, OP_EDONE, OP_ADIV, OP_ADONE, OP_SHIFT,
    OP_SUM, OP_MUL, OP_DDIV, OP_DDONE, OP_MUL2, OP_MUL3, OP_FINISH
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EDIV, S_EWAIT, S_ADIV, S_AWAIT, S_SHIFT, S_SUM, S_MUL,
    S_DDIV, S_DWAIT, S_MUL2, S_MUL3, S_FINISH
  } state_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic shift_zero;
    logic sum_last;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [WEIGHTS_W-1:0] weights;
    logic [GAIN_W-1:0]    p_gain;
    logic [GAIN_W-1:0]    d_fwd;
    logic [GAIN_W-1:0]    d_rev;
    logic [DUTY_W-1:0]    cruise;
    logic [PERIOD_W-1:0]  period;
  } cfg_t;

endpackage

// ===== hw/rtl/lfps_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module lfps_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 36,
  parameter int CNT_W = $clog2(NUM_W + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [CNT_W-1:0] nbits,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem,
  output logic             done
);

  logic [NUM_W-1:0] num_r, quo_r;
  logic [DEN_W-1:0] rem_r, den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic [CNT_W-1:0] shamt;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign shamt = CNT_W'(NUM_W) - nbits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      num_r  <= num << shamt;
      den_r  <= den;
      quo_r  <= '0;
      rem_r  <= '0;
      cnt_r  <= nbits;
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      rem_r <= ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
      num_r <= num_r << 1;
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule

// ===== hw/rtl/lfps_datapath.sv =====
// Datapath: line error, time accumulator, histories, derivative and wheel outputs.
`timescale 1ns / 1ps
module lfps_datapath
  import lfps_pkg::*;
#(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  cfg_t                 cfg,
  input  logic [NUM_SENSORS-1:0] in_sensors,
  input  logic [PERIOD_W-1:0]  in_elapsed_us,
  input  logic                 in_reverse,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic                 out_left_forward,
  output logic [DUTY_W-1:0]    out_left_duty,
  output logic                 out_right_forward,
  output logic [DUTY_W-1:0]    out_right_duty,
  output logic signed [ERR_W-1:0] out_line_error,
  output logic [HITS_W-1:0]    out_hit_count
);

  localparam int D       = HISTORY_DEPTH;
  localparam int IDX_W   = $clog2(D);
  localparam int NSH_W   = $clog2(D + 1);
  localparam int WT_CNT  = D * (D + 3) / 2;
  localparam int SUM_W   = ERR_W + 2 + $clog2(WT_CNT);
  localparam int MAG_W   = SUM_W - 1;
  localparam int NUM_W   = MAG_W + TICKS_W;
  localparam int DSQ     = D * D;
  localparam int DCUBE   = D * D * D;
  localparam int DK_W    = $clog2(DCUBE + 1);
  localparam int DEN_W   = PERIOD_W + DK_W;
  localparam int CNT_W   = $clog2(NUM_W + 1);
  localparam int WT_W    = $clog2(D + 2) + 1;
  localparam int X_W     = 64;
  localparam int V_W     = X_W + 2;

  typedef struct packed {
    logic              fwd;
    logic [DUTY_W-1:0] duty;
  } wheel_t;

  function automatic wheel_t wheel(input logic signed [V_W-1:0] v);
    logic signed [V_W-1:0] mag;
    wheel_t w;
    mag    = v[V_W-1] ? -v : v;
    w.fwd  = (v > 0);
    w.duty = (mag > V_W'(255)) ? 8'hFF : mag[DUTY_W-1:0];
    return w;
  endfunction

  // Item registers.
  logic signed [WSUM_W-1:0] wsum_r;
  logic [HITS_W-1:0]        hits_r;
  logic                     rev_r;
  logic signed [ERR_W-1:0]  e_r;
  logic [ACC_W-1:0]         acc_r;
  logic [PERIOD_W-1:0]      period_r;
  logic [DEN_W-1:0]         den_r;
  logic [NSH_W-1:0]         nshift_r;
  logic [IDX_W-1:0]         idx_r;
  logic signed [SUM_W-1:0]  s_r;
  logic [NUM_W-1:0]         prod_r;
  logic                     sneg_r;
  logic signed [NUM_W:0]    der_r;
  logic signed [X_W-1:0]    t1_r, t2_r, x_r;
  logic signed [ERR_W-1:0]  hist_fwd_r [D];
  logic signed [ERR_W-1:0]  hist_rev_r [D];

  logic                     out_valid_r, out_lf_r, out_rf_r;
  logic [DUTY_W-1:0]        out_ld_r, out_rd_r;
  logic signed [ERR_W-1:0]  out_err_r;
  logic [HITS_W-1:0]        out_hits_r;

  // Load-cycle combinational terms.
  logic signed [WSUM_W-1:0] wsum_c;
  logic [HITS_W-1:0]        hits_c;
  logic [PERIOD_W-1:0]      period_c;

  always_comb begin
    wsum_c = '0;
    hits_c = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (in_sensors[i]) begin
        wsum_c = wsum_c + WSUM_W'($signed(cfg.weights[8*i +: 8]));
        hits_c = hits_c + 1'b1;
      end
    end
    period_c = (cfg.period == '0) ? PERIOD_W'(1) : cfg.period;
  end

  // Divider operand selection.
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den, div_rem;
  logic [CNT_W-1:0] div_nbits;
  logic [WSUM_W-1:0] wsum_mag;

  assign wsum_mag = wsum_r[WSUM_W-1] ? WSUM_W'(-wsum_r) : WSUM_W'(wsum_r);

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_nbits = '0;
    case (cmd.op)
      OP_EDIV: begin
        div_start = 1'b1;
        div_num   = NUM_W'({wsum_mag, 4'b0});
        div_den   = DEN_W'(hits_r);
        div_nbits = CNT_W'(EDIV_BITS);
      end
      OP_ADIV: begin
        div_start = 1'b1;
        div_num   = NUM_W'(acc_r);
        div_den   = DEN_W'(period_r);
        div_nbits = CNT_W'(ACC_W);
      end
      OP_DDIV: begin
        div_start = 1'b1;
        div_num   = prod_r;
        div_den   = den_r;
        div_nbits = CNT_W'(NUM_W);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  lfps_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W),
    .CNT_W(CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .nbits (div_nbits),
    .quo   (div_quo),
    .rem   (div_rem),
    .done  (div_done)
  );

  // Derivative sum term for the current history entry.
  logic signed [ERR_W-1:0] h_sel;
  logic signed [SUM_W-1:0] diff_ext, wt_ext, term;
  logic [WT_W-1:0]         wt;

  assign h_sel    = rev_r ? hist_rev_r[idx_r] : hist_fwd_r[idx_r];
  assign wt       = rev_r ? (WT_W'(idx_r) + WT_W'(2)) : WT_W'(1);
  assign diff_ext = SUM_W'(e_r) - SUM_W'(h_sel);
  assign wt_ext   = SUM_W'(wt);
  assign term     = SUM_W'(diff_ext * wt_ext);

  logic [MAG_W-1:0]      s_mag;
  logic signed [X_W-1:0] der64, dg64, e64, p64, cr64, x_sel;
  logic signed [X_W-1:0] off_c;
  logic signed [V_W-1:0] off_v, cr_v, left_v, right_v;
  wheel_t                left_w, right_w;

  assign s_mag = s_r[SUM_W-1] ? MAG_W'(-s_r) : MAG_W'(s_r);
  assign der64 = X_W'(der_r);
  assign dg64  = X_W'({1'b0, rev_r ? cfg.d_rev : cfg.d_fwd});
  assign e64   = X_W'(e_r);
  assign p64   = X_W'({1'b0, cfg.p_gain});
  assign cr64  = X_W'({1'b0, cfg.cruise});
  assign x_sel = rev_r ? t1_r : X_W'(t1_r + t2_r);

  // Truncating division by 65536 toward zero.
  assign off_c = X_W'(x_r + (x_r[X_W-1] ? X_W'(65535) : X_W'(0))) >>> 16;
  assign off_v = V_W'(off_c);
  assign cr_v  = V_W'(cr64);

  always_comb begin
    if (!rev_r) begin
      if (off_v > 0) begin
        left_v  = cr_v;
        right_v = cr_v - off_v;
      end else begin
        right_v = cr_v;
        left_v  = cr_v + off_v;
      end
    end else begin
      if (off_v > 0) begin
        left_v  = -cr_v;
        right_v = -cr_v - off_v;
      end else begin
        right_v = -cr_v;
        left_v  = -cr_v + off_v;
      end
    end
    left_w  = wheel(left_v);
    right_w = wheel(right_v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      nshift_r    <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < D; i++) begin
        hist_fwd_r[i] <= '0;
        hist_rev_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && !out_stall && cmd.op != OP_FINISH) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD: begin
          wsum_r   <= wsum_c;
          hits_r   <= hits_c;
          rev_r    <= in_reverse;
          acc_r    <= acc_r + ACC_W'(in_elapsed_us);
          period_r <= period_c;
          den_r    <= DEN_W'(period_c) * (in_reverse ? DEN_W'(DCUBE) : DEN_W'(DSQ));
        end
        OP_EDONE: begin
          if (hits_r == '0) begin
            e_r <= '0;
          end else begin
            e_r <= wsum_r[WSUM_W-1] ? ERR_W'(-div_quo) : ERR_W'(div_quo);
          end
        end
        OP_ADONE: begin
          acc_r    <= div_rem[ACC_W-1:0];
          nshift_r <= (div_quo >= NUM_W'(D)) ? NSH_W'(D) : div_quo[NSH_W-1:0];
          idx_r    <= '0;
          s_r      <= '0;
        end
        OP_SHIFT: begin
          nshift_r <= nshift_r - 1'b1;
          if (rev_r) begin
            for (int i = D - 1; i > 0; i--) hist_rev_r[i] <= hist_rev_r[i-1];
            hist_rev_r[0] <= e_r;
          end else begin
            for (int i = D - 1; i > 0; i--) hist_fwd_r[i] <= hist_fwd_r[i-1];
            hist_fwd_r[0] <= e_r;
          end
        end
        OP_SUM: begin
          s_r   <= s_r + term;
          idx_r <= idx_r + 1'b1;
        end
        OP_MUL: begin
          prod_r <= NUM_W'(s_mag) * NUM_W'(TICKS_PER_SEC);
          sneg_r <= s_r[SUM_W-1];
        end
        OP_DDONE: begin
          der_r <= sneg_r ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
        end
        OP_MUL2: begin
          t1_r <= X_W'(der64 * dg64);
          t2_r <= X_W'(e64 * p64);
        end
        OP_MUL3: begin
          x_r <= X_W'(cr64 * x_sel);
        end
        OP_FINISH: begin
          out_valid_r <= 1'b1;
          out_lf_r    <= left_w.fwd;
          out_ld_r    <= left_w.duty;
          out_rf_r    <= right_w.fwd;
          out_rd_r    <= right_w.duty;
          out_err_r   <= e_r;
          out_hits_r  <= hits_r;
        end
        default: begin
        end
      endcase
    end
  end

  assign status.div_done   = div_done;
  assign status.shift_zero = (nshift_r == '0);
  assign status.sum_last   = (idx_r == IDX_W'(D - 1));
  assign status.out_free   = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_left_forward  = out_lf_r;
  assign out_left_duty     = out_ld_r;
  assign out_right_forward = out_rf_r;
  assign out_right_duty    = out_rd_r;
  assign out_line_error    = out_err_r;
  assign out_hit_count     = out_hits_r;

`ifndef SYNTHESIS
  a_nshift_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nshift_r <= NSH_W'(D))
    else $error("history shift count exceeds depth");

  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_FINISH |=> out_valid_r)
    else $error("finished word not presented");

  a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EDONE && hits_r == '0) |=> e_r == '0)
    else $error("line error nonzero with no sensor hit");
`endif

endmodule

// ===== hw/rtl/lfps_ctrl.sv =====
// Controller state machine that sequences the datapath for one word.
`timescale 1ns / 1ps
module lfps_ctrl
  import lfps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_EDIV;
        end
      end
      S_EDIV: begin
        cmd.op    = OP_EDIV;
        state_nxt = S_EWAIT;
      end
      S_EWAIT: begin
        if (status.div_done) begin
          cmd.op    = OP_EDONE;
          state_nxt = S_ADIV;
        end
      end
      S_ADIV: begin
        cmd.op    = OP_ADIV;
        state_nxt = S_AWAIT;
      end
      S_AWAIT: begin
        if (status.div_done) begin
          cmd.op    = OP_ADONE;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (status.shift_zero) begin
          state_nxt = S_SUM;
        end else begin
          cmd.op = OP_SHIFT;
        end
      end
      S_SUM: begin
        cmd.op = OP_SUM;
        if (status.sum_last) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_DDIV;
      end
      S_DDIV: begin
        cmd.op    = OP_DDIV;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (status.div_done) begin
          cmd.op    = OP_DDONE;
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        cmd.op    = OP_MUL2;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        cmd.op    = OP_MUL3;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // Hold the result until the output register can take it.
        if (status.out_free) begin
          cmd.op    = OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/line_follow_pd_steering_core.sv =====
// Top level of the line follower PD steering block with its register file.
`timescale 1ns / 1ps
// Each accepted word (five sensor hit bits, elapsed microseconds, direction)
// yields one result word with direction and duty per wheel, the Q12.4 line
// error and the hit count. Words are processed one at a time: a word goes
// through the line error division, the sampling period division, N history
// shifts (N at most HISTORY_DEPTH), one sum step per history entry, the
// derivative division and the gain multiplies. The run time is set by the
// shared one-bit-per-cycle divider, which serves the line error, the sampling
// period split and the derivative in turn, and by the one-entry-per-cycle
// history shift and sum. A finished word waits in an output register, so
// the next input word is taken while it is still stalled.
module line_follow_pd_steering_core
  import lfps_pkg::*;
#(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [NUM_SENSORS-1:0] in_sensors,
  input  logic [PERIOD_W-1:0]    in_elapsed_us,
  input  logic                   in_reverse,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_left_forward,
  output logic [DUTY_W-1:0]      out_left_duty,
  output logic                   out_right_forward,
  output logic [DUTY_W-1:0]      out_right_duty,
  output logic signed [ERR_W-1:0] out_line_error,
  output logic [HITS_W-1:0]      out_hit_count,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CADDR_W-1:0]     paddr,
  input  logic [CDATA_W-1:0]     pwdata,
  output logic [CDATA_W-1:0]     prdata,
  output logic                   pready
);

  cfg_t       cfg_r;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.weights <= '0;
      cfg_r.p_gain  <= RST_P_GAIN;
      cfg_r.d_fwd   <= '0;
      cfg_r.d_rev   <= '0;
      cfg_r.cruise  <= RST_CRUISE;
      cfg_r.period  <= RST_PERIOD;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WEIGHTS: cfg_r.weights <= pwdata[WEIGHTS_W-1:0];
        REG_P_GAIN:  cfg_r.p_gain  <= pwdata[GAIN_W-1:0];
        REG_D_FWD:   cfg_r.d_fwd   <= pwdata[GAIN_W-1:0];
        REG_D_REV:   cfg_r.d_rev   <= pwdata[GAIN_W-1:0];
        REG_CRUISE:  cfg_r.cruise  <= pwdata[DUTY_W-1:0];
        REG_PERIOD:  cfg_r.period  <= pwdata[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WEIGHTS: prdata = CDATA_W'(cfg_r.weights);
      REG_P_GAIN:  prdata = CDATA_W'(cfg_r.p_gain);
      REG_D_FWD:   prdata = CDATA_W'(cfg_r.d_fwd);
      REG_D_REV:   prdata = CDATA_W'(cfg_r.d_rev);
      REG_CRUISE:  prdata = CDATA_W'(cfg_r.cruise);
      REG_PERIOD:  prdata = CDATA_W'(cfg_r.period);
      default:     prdata = '0;
    endcase
  end

  lfps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lfps_datapath #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg               (cfg_r),
    .in_sensors        (in_sensors),
    .in_elapsed_us     (in_elapsed_us),
    .in_reverse        (in_reverse),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_left_forward  (out_left_forward),
    .out_left_duty     (out_left_duty),
    .out_right_forward (out_right_forward),
    .out_right_duty    (out_right_duty),
    .out_line_error    (out_line_error),
    .out_hit_count     (out_hit_count)
  );

endmodule

// ===== verif/line_follow_pd_steering_core_tb.sv =====
// Self-checking testbench for the line follower PD steering core.
`timescale 1ns / 1ps
module line_follow_pd_steering_core_tb;
  import lfps_pkg::*;

  localparam int DEPTH = DEF_HISTORY_DEPTH;
  localparam int LIMIT_CYCLES = 1500000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic                    left_fwd;
    logic [DUTY_W-1:0]       left_duty;
    logic                    right_fwd;
    logic [DUTY_W-1:0]       right_duty;
    logic signed [ERR_W-1:0] line_err;
    logic [HITS_W-1:0]       hits;
  } steer_word_t;

  class steering_scoreboard;
    logic [WEIGHTS_W-1:0] weights;
    logic [GAIN_W-1:0]    p_gain, d_fwd, d_rev;
    logic [DUTY_W-1:0]    cruise;
    logic [PERIOD_W-1:0]  period;
    longint               acc;
    int                   fwd_hist[DEPTH];
    int                   rev_hist[DEPTH];
    steer_word_t          expected_q[$];
    int                   errors;

    function new();
      weights = '0;
      p_gain = RST_P_GAIN;
      d_fwd = '0;
      d_rev = '0;
      cruise = RST_CRUISE;
      period = RST_PERIOD;
      acc = 0;
      foreach (fwd_hist[i]) fwd_hist[i] = 0;
      foreach (rev_hist[i]) rev_hist[i] = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [CDATA_W-1:0] v);
      case (idx)
        REG_WEIGHTS: weights = v[WEIGHTS_W-1:0];
        REG_P_GAIN:  p_gain = v[GAIN_W-1:0];
        REG_D_FWD:   d_fwd = v[GAIN_W-1:0];
        REG_D_REV:   d_rev = v[GAIN_W-1:0];
        REG_CRUISE:  cruise = v[DUTY_W-1:0];
        REG_PERIOD:  period = v[PERIOD_W-1:0];
        default: ;
      endcase
    endfunction

    function void wheel(longint v, output logic fwd, output logic [DUTY_W-1:0] duty);
      longint mag;
      mag = v < 0 ? -v : v;
      fwd = v > 0;
      duty = mag > 255 ? 8'd255 : mag[7:0];
    endfunction

    function void note_word(logic [4:0] bits, logic [PERIOD_W-1:0] elapsed, logic rev);
      logic signed [7:0] w;
      int          wsum, hits, e, shifts;
      longint      per, s, der, off, left, right, crz;
      int          h[DEPTH];
      steer_word_t r;
      wsum = 0;
      hits = 0;
      e = 0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        if (bits[i]) begin
          w = weights[8*i +: 8];
          wsum += w;
          hits++;
        end
      end
      if (hits > 0) e = (wsum * 16) / hits;
      per = (period == 0) ? 1 : longint'(period);
      acc += elapsed;
      shifts = (acc / per) < DEPTH ? int'(acc / per) : DEPTH;
      acc = acc % per;
      if (rev) h = rev_hist;
      else h = fwd_hist;
      for (int k = 0; k < shifts; k++) begin
        for (int j = DEPTH - 1; j > 0; j--) h[j] = h[j-1];
        h[0] = e;
      end
      crz = longint'(cruise);
      s = 0;
      if (!rev) begin
        fwd_hist = h;
        for (int i = 0; i < DEPTH; i++) s += longint'(e) - h[i];
        der = s * TICKS_PER_SEC / (DEPTH * DEPTH * per);
        off = crz * (longint'(e) * longint'(p_gain) + der * longint'(d_fwd)) / 65536;
        if (off > 0) begin
          left = crz;
          right = crz - off;
        end else begin
          right = crz;
          left = crz + off;
        end
      end else begin
        rev_hist = h;
        for (int i = 0; i < DEPTH; i++) s += (longint'(e) - h[i]) * (i + 2);
        der = s * TICKS_PER_SEC / (DEPTH * DEPTH * DEPTH * per);
        off = crz * der * longint'(d_rev) / 65536;
        if (off > 0) begin
          left = -crz;
          right = -crz - off;
        end else begin
          right = -crz;
          left = -crz + off;
        end
      end
      wheel(left, r.left_fwd, r.left_duty);
      wheel(right, r.right_fwd, r.right_duty);
      r.line_err = e[ERR_W-1:0];
      r.hits = hits[HITS_W-1:0];
      expected_q.push_back(r);
    endfunction

    function void check_word(steer_word_t got);
      steer_word_t exp_w;
      if (expected_q.size() == 0) begin
        $error("result word with no expectation waiting");
        errors++;
        return;
      end
      exp_w = expected_q.pop_front();
      if (got.left_fwd !== exp_w.left_fwd) begin
        $error("left_forward: expected %0d got %0d", exp_w.left_fwd, got.left_fwd);
        errors++;
      end
      if (got.left_duty !== exp_w.left_duty) begin
        $error("left_duty: expected %0d got %0d", exp_w.left_duty, got.left_duty);
        errors++;
      end
      if (got.right_fwd !== exp_w.right_fwd) begin
        $error("right_forward: expected %0d got %0d", exp_w.right_fwd, got.right_fwd);
        errors++;
      end
      if (got.right_duty !== exp_w.right_duty) begin
        $error("right_duty: expected %0d got %0d", exp_w.right_duty, got.right_duty);
        errors++;
      end
      if (got.line_err !== exp_w.line_err) begin
        $error("line_error: expected %0d got %0d", exp_w.line_err, got.line_err);
        errors++;
      end
      if (got.hits !== exp_w.hits) begin
        $error("hit_count: expected %0d got %0d", exp_w.hits, got.hits);
        errors++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [NUM_SENSORS-1:0]  in_sensors;
  logic [PERIOD_W-1:0]     in_elapsed_us;
  logic                    in_reverse;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_left_forward;
  logic [DUTY_W-1:0]       out_left_duty;
  logic                    out_right_forward;
  logic [DUTY_W-1:0]       out_right_duty;
  logic signed [ERR_W-1:0] out_line_error;
  logic [HITS_W-1:0]       out_hit_count;
  logic                    psel, penable, pwrite, pready;
  logic [CADDR_W-1:0]      paddr;
  logic [CDATA_W-1:0]      pwdata, prdata;

  steering_scoreboard sb;
  bit                 hold_request;
  longint             cycle_count;

  line_follow_pd_steering_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sensors(in_sensors),
    .in_elapsed_us(in_elapsed_us), .in_reverse(in_reverse),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_left_forward(out_left_forward), .out_left_duty(out_left_duty),
    .out_right_forward(out_right_forward), .out_right_duty(out_right_duty),
    .out_line_error(out_line_error), .out_hit_count(out_hit_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: runs of stall and no stall, plus one long hold on request.
  initial begin : result_stall
    int run_left;
    int hold_left;
    bit stall_now;
    int r;
    run_left = 0;
    hold_left = 0;
    stall_now = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        stall_now = 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 400;
        stall_now = 1'b1;
      end else begin
        if (run_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 50) begin
            stall_now = 1'b0;
            run_left = $urandom_range(1, 20);
          end else if (r < 85) begin
            stall_now = 1'b1;
            run_left = $urandom_range(1, 3);
          end else if (r < 95) begin
            stall_now = 1'b0;
            run_left = $urandom_range(50, 200);
          end else begin
            stall_now = 1'b1;
            run_left = $urandom_range(20, 60);
          end
        end
        run_left--;
      end
      out_stall <= stall_now;
    end
  end

  always @(posedge clk) begin
    steer_word_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.left_fwd = out_left_forward;
      got.left_duty = out_left_duty;
      got.right_fwd = out_right_forward;
      got.right_duty = out_right_duty;
      got.line_err = out_line_error;
      got.hits = out_hit_count;
      sb.check_word(got);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [CDATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CADDR_W'(idx * 8);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_word(logic [4:0] bits, logic [PERIOD_W-1:0] elapsed, logic rev);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 4);
    else gap = $urandom_range(10, 60);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_sensors <= bits;
    in_elapsed_us <= elapsed;
    in_reverse <= rev;
    do @(posedge clk); while (in_stall);
    sb.note_word(bits, elapsed, rev);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  function automatic logic [PERIOD_W-1:0] pick_elapsed(logic [PERIOD_W-1:0] per);
    int     r;
    longint p, v;
    r = $urandom_range(0, 9);
    p = (per == 0) ? 1 : per;
    if (r < 4) v = $urandom_range(0, int'(p));
    else if (r < 6) v = longint'($urandom_range(0, 9)) * p + $urandom_range(0, 3);
    else if (r == 6) v = 0;
    else if (r == 7) v = 20'hFFFFF;
    else v = $urandom & 20'hFFFFF;
    return v > 20'hFFFFF ? 20'hFFFFF : v[PERIOD_W-1:0];
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return '0;
    if (r == 1) return 16'hFFFF;
    return GAIN_W'($urandom_range(0, 2047));
  endfunction

  initial begin
    logic [PERIOD_W-1:0] per;
    logic [CDATA_W-1:0]  wv;
    bit                  rev_mode;
    int                  r;
    sb = new();
    cycle_count = 0;
    hold_request = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sensors = '0;
    in_elapsed_us = '0;
    in_reverse = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: zero weights give no error; a no-hit word too.
    send_word(5'd0, 20'd0, 1'b0);
    send_word(5'd31, 20'd10000, 1'b0);
    send_word(5'd31, 20'hFFFFF, 1'b1);
    end_burst();
    wait_idle();

    // Weights at both signed extremes, a short period and live gains.
    write_reg(REG_WEIGHTS, 64'h10_7F_80_7F_80);
    write_reg(REG_P_GAIN, 64'hFFFF);
    write_reg(REG_D_FWD, 64'd300);
    write_reg(REG_D_REV, 64'd500);
    write_reg(REG_CRUISE, 64'd255);
    write_reg(REG_PERIOD, 64'd100);
    for (int i = 0; i < NUM_SENSORS; i++) send_word(5'(1 << i), 20'd100, 1'b0);
    send_word(5'b00011, 20'd0, 1'b0);
    send_word(5'b11111, 20'd99, 1'b0);
    send_word(5'b00000, 20'd1, 1'b0);
    send_word(5'b00001, 20'd5000, 1'b1);
    send_word(5'b00010, 20'd100, 1'b1);
    send_word(5'b00000, 20'd100, 1'b1);
    send_word(5'b10101, 20'hFFFFF, 1'b0);
    end_burst();
    wait_idle();

    // Zero period counts as one microsecond; zero cruise stops both wheels.
    write_reg(REG_PERIOD, 64'd0);
    write_reg(REG_CRUISE, 64'd0);
    send_word(5'b00001, 20'd3, 1'b0);
    send_word(5'b10000, 20'd0, 1'b1);
    end_burst();
    wait_idle();
    write_reg(REG_CRUISE, 64'd128);
    send_word(5'b00001, 20'd2, 1'b0);
    send_word(5'b10000, 20'd1, 1'b1);
    send_word(5'b00110, 20'd9, 1'b1);
    end_burst();
    wait_idle();

    // Random phases, each with its own settings.
    for (int phase = 0; phase < 8; phase++) begin
      r = $urandom_range(0, 5);
      case (r)
        0: per = 20'd0;
        1: per = 20'd1;
        2: per = 20'hFFFFF;
        3: per = 20'd10000;
        default: per = PERIOD_W'($urandom_range(20, 3000));
      endcase
      wv = {$urandom, $urandom};
      if (phase == 1) wv = 64'hFF_FF_FF_FF_FF;
      write_reg(REG_WEIGHTS, wv);
      write_reg(REG_P_GAIN, pick_gain());
      write_reg(REG_D_FWD, pick_gain());
      write_reg(REG_D_REV, pick_gain());
      r = $urandom_range(0, 3);
      write_reg(REG_CRUISE, r == 0 ? 64'd255 : (r == 1 ? 64'd0 : 64'($urandom_range(1, 254))));
      write_reg(REG_PERIOD, per);
      rev_mode = 1'($urandom_range(0, 1));
      for (int n = 0; n < 150; n++) begin
        // Mostly runs in one direction so the histories fill up.
        if ($urandom_range(0, 19) == 0) rev_mode = ~rev_mode;
        if (phase == 3 && n == 40) hold_request = 1'b1;
        send_word(5'($urandom_range(0, 31)), pick_elapsed(per),
                  $urandom_range(0, 9) == 0 ? ~rev_mode : rev_mode);
      end
      end_burst();
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
